[rtl/core/phr_pkg.sv]
`timescale 1ns / 1ps

package phr_pkg;

  // Item kinds carried on the input tuser field.
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_SLOT  = 2'd1,
    KIND_RESET = 2'd2,
    KIND_ARM   = 2'd3
  } kind_t;

  // Reasons reported with a headroom report.
  typedef enum logic [1:0] {
    REASON_NONE     = 2'd0,
    REASON_PERIODIC = 2'd1,
    REASON_PATHLOSS = 2'd2,
    REASON_POWER    = 2'd3
  } reason_t;

  // Configuration register indexes (byte address is four times the index).
  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_PERIODIC  = 2'd1,
    REG_PROHIBIT  = 2'd2,
    REG_THRESHOLD = 2'd3
  } reg_idx_t;

  localparam int DB_WIDTH        = 11;
  localparam int PERIOD_WIDTH    = 16;
  localparam int THRESH_WIDTH    = 10;
  localparam int INDEX_WIDTH     = 6;
  localparam int HEADROOM_OFFSET = 23;
  localparam int HEADROOM_MAX    = 63;

  // One input item after unpacking.
  typedef struct packed {
    kind_t                        kind;
    logic signed [DB_WIDTH-1:0]   max_tx_power;
    logic signed [DB_WIDTH-1:0]   estimated_tx_power;
    logic signed [DB_WIDTH-1:0]   actual_tx_power;
    logic        [DB_WIDTH-1:0]   path_loss;
    logic                         new_grant;
  } item_t;

  // Configuration register set.
  typedef struct packed {
    logic                      report_enable;
    logic [PERIOD_WIDTH-1:0]   periodic_period;
    logic [PERIOD_WIDTH-1:0]   prohibit_period;
    logic [THRESH_WIDTH-1:0]   change_threshold;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic                     triggered;
    reason_t                  trigger_reason;
    logic [INDEX_WIDTH-1:0]   headroom_index;
  } result_t;

endpackage

[rtl/core/phr_in_reg.sv]
`timescale 1ns / 1ps

module phr_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic           drain,
  input  phr_pkg::item_t item_in,
  output logic           valid,
  output phr_pkg::item_t item
);

  // Occupancy of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (drain) begin
      valid <= 1'b0;
    end
  end

  // Payload capture; no reset needed.
  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

[rtl/core/phr_eval.sv]
`timescale 1ns / 1ps

module phr_eval #(
  parameter int TIMER_WIDTH   = 16,
  parameter int FRACTION_BITS = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  phr_pkg::cfg_t    cfg,
  input  phr_pkg::item_t   item,
  input  logic             fire,
  output logic             has_result,
  output phr_pkg::result_t result
);

  localparam int CMP_WIDTH = (TIMER_WIDTH > phr_pkg::PERIOD_WIDTH) ?
                             TIMER_WIDTH : phr_pkg::PERIOD_WIDTH;
  localparam int DW = phr_pkg::DB_WIDTH;
  localparam logic signed [DW+1:0] HR_OFFSET = (DW+2)'(phr_pkg::HEADROOM_OFFSET);
  localparam logic signed [DW+1:0] HR_MAX    = (DW+2)'(phr_pkg::HEADROOM_MAX);

  logic [TIMER_WIDTH-1:0] periodic_count, periodic_count_next;
  logic [TIMER_WIDTH-1:0] prohibit_count, prohibit_count_next;
  logic [DW-1:0]          last_path_loss, last_path_loss_next;
  logic signed [DW-1:0]   last_tx_power, last_tx_power_next;
  logic                   trigger_pending, trigger_pending_next;

  logic                   periodic_fire, change_gate, pathloss_fire, power_fire, report;
  logic signed [DW:0]     pl_diff, pw_diff;
  logic [DW:0]            pl_abs, pw_abs, thr_ext;
  logic signed [DW:0]     hr_diff, hr_quot;
  logic signed [DW+1:0]   hr_sum;
  logic [phr_pkg::INDEX_WIDTH-1:0] hr_index;
  phr_pkg::reason_t       reason;

  assign has_result = cfg.report_enable && (item.kind == phr_pkg::KIND_SLOT);

  // Trigger checks against the stored state.
  always_comb begin
    periodic_fire = (cfg.periodic_period != '0) &&
                    (CMP_WIDTH'(periodic_count) >= CMP_WIDTH'(cfg.periodic_period));
    change_gate   = item.new_grant && (cfg.change_threshold != '0) &&
                    (CMP_WIDTH'(prohibit_count) >= CMP_WIDTH'(cfg.prohibit_period));
    pl_diff = $signed({1'b0, item.path_loss}) - $signed({1'b0, last_path_loss});
    pw_diff = $signed({item.actual_tx_power[DW-1], item.actual_tx_power}) -
              $signed({last_tx_power[DW-1], last_tx_power});
    pl_abs  = pl_diff[DW] ? (DW+1)'(-pl_diff) : (DW+1)'(pl_diff);
    pw_abs  = pw_diff[DW] ? (DW+1)'(-pw_diff) : (DW+1)'(pw_diff);
    thr_ext = (DW+1)'(cfg.change_threshold);
    pathloss_fire = change_gate && (pl_abs > thr_ext);
    power_fire    = change_gate && (pw_abs > thr_ext);
    report = trigger_pending || periodic_fire || pathloss_fire || power_fire;
    if (power_fire) begin
      reason = phr_pkg::REASON_POWER;
    end else if (pathloss_fire) begin
      reason = phr_pkg::REASON_PATHLOSS;
    end else if (periodic_fire) begin
      reason = phr_pkg::REASON_PERIODIC;
    end else begin
      reason = phr_pkg::REASON_NONE;
    end
  end

  // Headroom index: floor of the difference in whole dB, offset and clamped.
  always_comb begin
    hr_diff = $signed({item.max_tx_power[DW-1], item.max_tx_power}) -
              $signed({item.estimated_tx_power[DW-1], item.estimated_tx_power});
    hr_quot = hr_diff >>> FRACTION_BITS;
    hr_sum  = $signed({hr_quot[DW], hr_quot}) + HR_OFFSET;
    if (hr_sum < 0) begin
      hr_index = '0;
    end else if (hr_sum > HR_MAX) begin
      hr_index = phr_pkg::INDEX_WIDTH'(phr_pkg::HEADROOM_MAX);
    end else begin
      hr_index = hr_sum[phr_pkg::INDEX_WIDTH-1:0];
    end
  end

  // Result of a slot item.
  always_comb begin
    result = '0;
    if (report) begin
      result.triggered      = 1'b1;
      result.trigger_reason = reason;
      result.headroom_index = hr_index;
    end
  end

  // Next state for the item leaving the input register.
  always_comb begin
    periodic_count_next  = periodic_count;
    prohibit_count_next  = prohibit_count;
    last_path_loss_next  = last_path_loss;
    last_tx_power_next   = last_tx_power;
    trigger_pending_next = trigger_pending;
    if (cfg.report_enable) begin
      case (item.kind)
        phr_pkg::KIND_TICK: begin
          if (periodic_count != '1) begin
            periodic_count_next = periodic_count + TIMER_WIDTH'(1);
          end
          if (prohibit_count != '1) begin
            prohibit_count_next = prohibit_count + TIMER_WIDTH'(1);
          end
        end
        phr_pkg::KIND_SLOT: begin
          if (periodic_fire) begin
            periodic_count_next = '0;
          end
          if (pathloss_fire || power_fire) begin
            prohibit_count_next = '0;
          end
          if (report) begin
            last_path_loss_next = item.path_loss;
            last_tx_power_next  = item.actual_tx_power;
          end
          trigger_pending_next = 1'b0;
        end
        phr_pkg::KIND_RESET: begin
          periodic_count_next  = '0;
          prohibit_count_next  = '0;
          last_path_loss_next  = '0;
          last_tx_power_next   = '0;
          trigger_pending_next = 1'b0;
        end
        phr_pkg::KIND_ARM: begin
          periodic_count_next  = '0;
          prohibit_count_next  = '0;
          trigger_pending_next = 1'b1;
        end
        default: begin
          trigger_pending_next = trigger_pending;
        end
      endcase
    end
  end

  // Trigger state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_count  <= '0;
      prohibit_count  <= '0;
      last_path_loss  <= '0;
      last_tx_power   <= '0;
      trigger_pending <= 1'b0;
    end else if (fire) begin
      periodic_count  <= periodic_count_next;
      prohibit_count  <= prohibit_count_next;
      last_path_loss  <= last_path_loss_next;
      last_tx_power   <= last_tx_power_next;
      trigger_pending <= trigger_pending_next;
    end
  end

endmodule

[rtl/core/power_headroom_report_trigger_core.sv]
`timescale 1ns / 1ps

// Power headroom report trigger.
// Input items arrive on the s_ stream: tuser carries the kind (tick, slot,
// reset state, arm) and tdata the power, pathloss and grant fields. Only slot
// items produce a result, one per slot while report_enable is set; tick,
// reset and arm items update the timers and trigger state and produce none.
// Results leave on the m_ stream: triggered, reason and headroom index.
// An accepted item is held in the input register until a stalled output
// register no longer blocks it; its result then loads the output register.
// One item per cycle is sustained while the receiver does not stall; the
// trigger logic between the input and output registers is combinational.
// When the receiver stalls, a waiting result holds in the output register,
// the input register still takes one more item, and s_tready drops only
// when that item is a slot item with report_enable set and nowhere to put
// its result. Configuration goes through the APB port; the user writes it
// only while the block is idle, which the block itself does not enforce.
// Synchronous reset clears cfg, valid flags, timers, stored pathloss/power.
module power_headroom_report_trigger_core #(
  parameter int TIMER_WIDTH   = 16,
  parameter int FRACTION_BITS = 3
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: max_tx_power[10:0], estimated_tx_power[21:11],
  //          actual_tx_power[32:22], path_loss[43:33], new_grant[44], zero pad
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,
  // s_tuser: kind[1:0]
  input  logic [1:0]  s_tuser,
  // m_tdata: triggered[0], trigger_reason[2:1], headroom_index[8:3], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  phr_pkg::cfg_t    cfg;
  phr_pkg::item_t   item_in, item;
  phr_pkg::result_t result, out_result;
  logic             in_valid, has_result, fire, accept, cfg_write;
  phr_pkg::reg_idx_t reg_idx;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_idx   = phr_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        phr_pkg::REG_ENABLE:    cfg.report_enable    <= pwdata[0];
        phr_pkg::REG_PERIODIC:  cfg.periodic_period  <= pwdata[15:0];
        phr_pkg::REG_PROHIBIT:  cfg.prohibit_period  <= pwdata[15:0];
        phr_pkg::REG_THRESHOLD: cfg.change_threshold <= pwdata[9:0];
        default:                cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      phr_pkg::REG_ENABLE:    prdata = 32'(cfg.report_enable);
      phr_pkg::REG_PERIODIC:  prdata = 32'(cfg.periodic_period);
      phr_pkg::REG_PROHIBIT:  prdata = 32'(cfg.prohibit_period);
      phr_pkg::REG_THRESHOLD: prdata = 32'(cfg.change_threshold);
      default:                prdata = '0;
    endcase
  end

  // Input unpacking and handshake.
  always_comb begin
    item_in.kind               = phr_pkg::kind_t'(s_tuser);
    item_in.max_tx_power       = $signed(s_tdata[10:0]);
    item_in.estimated_tx_power = $signed(s_tdata[21:11]);
    item_in.actual_tx_power    = $signed(s_tdata[32:22]);
    item_in.path_loss          = s_tdata[43:33];
    item_in.new_grant          = s_tdata[44];
  end

  // The held item moves on unless it needs the output register and that is full and stalled.
  assign fire     = in_valid && (!has_result || !m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;
  assign accept   = s_tvalid && s_tready;

  phr_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .drain   (fire),
    .item_in (item_in),
    .valid   (in_valid),
    .item    (item)
  );

  phr_eval #(
    .TIMER_WIDTH   (TIMER_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_eval (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .fire       (fire),
    .has_result (has_result),
    .result     (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && has_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      out_result <= result;
    end
  end

  assign m_tdata = {7'b0, out_result.headroom_index, out_result.trigger_reason,
                    out_result.triggered};

`ifndef SYNTHESIS
  // A report without a trigger carries a zero reason and index.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == 8'd0))
    else $error("non-triggered result has nonzero fields");

  // A slot item must not leave the input register while a result is stalled.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && has_result && m_tvalid && !m_tready) |-> (!fire && !s_tready))
    else $error("slot item advanced into a stalled output register");

  // A result appears only after a slot item was evaluated with the block enabled.
  assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid)) |-> $past(fire && has_result))
    else $error("result appeared without a slot item");
`endif

endmodule

[tb/power_headroom_report_trigger_core_test.sv]
`timescale 1ns / 1ps

import phr_pkg::*;

// Tracks the trigger state of the block and holds the reports it should produce.
class phr_scoreboard #(int TW = 16, int FB = 3);
  // Register copies.
  bit                    enable;
  bit [PERIOD_WIDTH-1:0] periodic_period;
  bit [PERIOD_WIDTH-1:0] prohibit_period;
  bit [THRESH_WIDTH-1:0] threshold;

  // Trigger state.
  bit [TW-1:0]              periodic_count;
  bit [TW-1:0]              prohibit_count;
  bit [DB_WIDTH-1:0]        last_path_loss;
  bit signed [DB_WIDTH-1:0] last_power;
  bit                       pending;

  result_t expected_reports[$];
  int      errors;
  int      results_seen;
  int      reports_by_reason[4];

  function void write_reg(reg_idx_t idx, logic [31:0] value);
    case (idx)
      REG_ENABLE:    enable = value[0];
      REG_PERIODIC:  periodic_period = value[PERIOD_WIDTH-1:0];
      REG_PROHIBIT:  prohibit_period = value[PERIOD_WIDTH-1:0];
      REG_THRESHOLD: threshold = value[THRESH_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  // Headroom in whole dB rounded down, offset and clamped to the index range.
  function int headroom_index(int maxp, int est);
    int q;
    int idx;
    q = (maxp - est) >>> FB;
    idx = q + HEADROOM_OFFSET;
    if (idx < 0) idx = 0;
    if (idx > HEADROOM_MAX) idx = HEADROOM_MAX;
    return idx;
  endfunction

  // Called for every accepted input item.
  function void note_item(item_t it);
    result_t  r;
    reason_t  why;
    int       d_pl;
    int       d_pw;
    int       act;
    if (!enable) return;
    case (it.kind)
      KIND_TICK: begin
        if (periodic_count != {TW{1'b1}}) periodic_count++;
        if (prohibit_count != {TW{1'b1}}) prohibit_count++;
      end
      KIND_RESET: begin
        periodic_count = '0;
        prohibit_count = '0;
        last_path_loss = '0;
        last_power = '0;
        pending = 1'b0;
      end
      KIND_ARM: begin
        periodic_count = '0;
        prohibit_count = '0;
        pending = 1'b1;
      end
      default: begin
        why = REASON_NONE;
        act = int'($signed(it.actual_tx_power));
        if (periodic_period != 0 && periodic_count >= periodic_period) begin
          pending = 1'b1;
          periodic_count = '0;
          why = REASON_PERIODIC;
        end
        // Change triggers: only on a new grant, outside the prohibit window.
        if (it.new_grant && prohibit_count >= prohibit_period && threshold != 0) begin
          d_pl = int'(last_path_loss) - int'(it.path_loss);
          if (d_pl < 0) d_pl = -d_pl;
          d_pw = int'(last_power) - act;
          if (d_pw < 0) d_pw = -d_pw;
          if (d_pl > int'(threshold)) begin
            pending = 1'b1;
            prohibit_count = '0;
            why = REASON_PATHLOSS;
          end
          if (d_pw > int'(threshold)) begin
            pending = 1'b1;
            prohibit_count = '0;
            why = REASON_POWER;
          end
        end
        if (pending) begin
          last_path_loss = it.path_loss;
          last_power = it.actual_tx_power;
          r.triggered = 1'b1;
          r.trigger_reason = why;
          r.headroom_index = INDEX_WIDTH'(headroom_index(int'($signed(it.max_tx_power)),
                                                         int'($signed(it.estimated_tx_power))));
        end else begin
          r = '0;
        end
        pending = 1'b0;
        expected_reports.push_back(r);
      end
    endcase
  endfunction

  // Called for every accepted result item.
  function void check_result(logic [15:0] data);
    result_t want;
    results_seen++;
    if (expected_reports.size() == 0) begin
      $error("result with no report pending: m_tdata %h", data);
      errors++;
      return;
    end
    want = expected_reports.pop_front();
    if (data[0] !== want.triggered) begin
      $error("triggered mismatch: expected %0d, actual %0d", want.triggered, data[0]);
      errors++;
    end
    if (data[2:1] !== want.trigger_reason) begin
      $error("trigger_reason mismatch: expected %0d, actual %0d",
             want.trigger_reason, data[2:1]);
      errors++;
    end
    if (data[8:3] !== want.headroom_index) begin
      $error("headroom_index mismatch: expected %0d, actual %0d",
             want.headroom_index, data[8:3]);
      errors++;
    end
    if (want.triggered) reports_by_reason[want.trigger_reason]++;
  endfunction
endclass

module power_headroom_report_trigger_core_test;
  localparam int TIMER_W      = 16;
  localparam int FRAC_W       = 3;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = KIND_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  phr_scoreboard #(TIMER_W, FRAC_W) sb;

  int src_idle_pct = 34;
  int sink_idle_pct = 34;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;

  power_headroom_report_trigger_core #(
    .TIMER_WIDTH  (TIMER_W),
    .FRACTION_BITS(FRAC_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Result side: check each accepted item, stall at random or for a requested hold.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tdata);
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("power_headroom_report_trigger_core verification failed");
      $finish;
    end
  end

  function automatic item_t mk(kind_t k, int maxp, int est, int act, int pl, bit grant);
    item_t it;
    it.kind = k;
    it.max_tx_power = maxp[DB_WIDTH-1:0];
    it.estimated_tx_power = est[DB_WIDTH-1:0];
    it.actual_tx_power = act[DB_WIDTH-1:0];
    it.path_loss = pl[DB_WIDTH-1:0];
    it.new_grant = grant;
    return it;
  endfunction

  // Power value biased toward the extremes and zero.
  function automatic logic [DB_WIDTH-1:0] rand_db();
    case ($urandom_range(7))
      0: return 11'h400;
      1: return 11'h3FF;
      2: return '0;
      default: return DB_WIDTH'($urandom);
    endcase
  endfunction

  // Value a little either side of the threshold away from the stored one.
  function automatic logic [DB_WIDTH-1:0] near_threshold(logic [DB_WIDTH-1:0] last);
    int off;
    off = int'(sb.threshold) + int'($urandom_range(2)) - 1;
    if ($urandom_range(1)) off = -off;
    return last + off[DB_WIDTH-1:0];
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    r;
    r = $urandom_range(99);
    if (r < 40) it.kind = KIND_TICK;
    else if (r < 88) it.kind = KIND_SLOT;
    else if (r < 94) it.kind = KIND_ARM;
    else it.kind = KIND_RESET;
    it.max_tx_power = rand_db();
    // Half the time keep the estimate near the maximum, mostly in the unclamped range.
    if ($urandom_range(1)) begin
      it.estimated_tx_power = it.max_tx_power + DB_WIDTH'(int'($urandom_range(480)) - 240);
    end else begin
      it.estimated_tx_power = rand_db();
    end
    case ($urandom_range(3))
      0: it.path_loss = near_threshold(sb.last_path_loss);
      1: it.path_loss = $urandom_range(1) ? 11'h7FF : 11'h000;
      default: it.path_loss = DB_WIDTH'($urandom);
    endcase
    case ($urandom_range(3))
      0: it.actual_tx_power = near_threshold(sb.last_power);
      default: it.actual_tx_power = rand_db();
    endcase
    it.new_grant = ($urandom_range(3) != 0);
    return it;
  endfunction

  // Offer one item, with random idle cycles ahead of it, and note it on acceptance.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.kind;
    s_tdata <= {3'b000, it.new_grant, it.path_loss, it.actual_tx_power,
                it.estimated_tx_power, it.max_tx_power};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(random_item());
  endtask

  // Stop offering and let every pending report and any trailing work drain.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write followed by a read-back check.
  task automatic reg_access(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] mask;
    case (idx)
      REG_ENABLE:    mask = 32'h1;
      REG_THRESHOLD: mask = 32'((1 << THRESH_WIDTH) - 1);
      default:       mask = 32'((1 << PERIOD_WIDTH) - 1);
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== (value & mask)) begin
      $error("register %0d read-back mismatch: expected %h, actual %h",
             idx, value & mask, prdata);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input bit en, input int per, input int proh, input int thr);
    wait_idle();
    reg_access(REG_ENABLE, 32'(en));
    reg_access(REG_PERIODIC, 32'(per));
    reg_access(REG_PROHIBIT, 32'(proh));
    reg_access(REG_THRESHOLD, 32'(thr));
  endtask

  initial begin
    item_t it;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Disabled after reset: every kind is ignored and nothing comes out.
    send_item(mk(KIND_ARM, 0, 0, 0, 0, 1));
    send_item(mk(KIND_TICK, 0, 0, 0, 0, 0));
    send_item(mk(KIND_SLOT, 1023, -1024, 1023, 2047, 1));
    send_item(mk(KIND_RESET, 0, 0, 0, 0, 0));

    // Directed walk through forced, periodic, pathloss and power reports.
    configure(1'b1, 3, 2, 16);
    send_item(mk(KIND_SLOT, 0, 0, 0, 0, 0));
    send_item(mk(KIND_ARM, 0, 0, 0, 0, 0));
    send_item(mk(KIND_SLOT, 1023, -1024, 1023, 2047, 0));
    send_item(mk(KIND_ARM, 0, 0, 0, 0, 0));
    send_item(mk(KIND_SLOT, -1024, 1023, -1024, 0, 1));
    repeat (3) send_item(mk(KIND_TICK, 0, 0, 0, 0, 0));
    send_item(mk(KIND_SLOT, 100, 100, -1024, 0, 0));
    repeat (2) send_item(mk(KIND_TICK, 0, 0, 0, 0, 0));
    send_item(mk(KIND_SLOT, 80, 85, -1024, 17, 1));
    repeat (2) send_item(mk(KIND_TICK, 0, 0, 0, 0, 0));
    // Periodic and power change together: the power change names the reason.
    send_item(mk(KIND_SLOT, 0, 7, -1007, 17, 1));
    repeat (2) send_item(mk(KIND_TICK, 0, 0, 0, 0, 0));
    // Changes exactly at the threshold do not trigger.
    send_item(mk(KIND_SLOT, 0, 0, -991, 33, 1));
    send_item(mk(KIND_SLOT, 8, 0, -991, 1000, 1));
    // Inside the prohibit window a large change is held back.
    send_item(mk(KIND_SLOT, 0, 0, 1023, 0, 1));
    send_item(mk(KIND_RESET, 0, 0, 0, 0, 0));
    send_item(mk(KIND_SLOT, 0, 0, 0, 0, 1));

    // Short timers, then a long receiver hold while slots keep coming.
    configure(1'b1, 4, 3, 8);
    send_random(80);
    hold_req <= hold_req + 1;
    src_idle_pct = 0;
    repeat (30) begin
      it = random_item();
      it.kind = KIND_SLOT;
      send_item(it);
    end
    src_idle_pct = 34;
    wait_idle();
    send_random(40);

    // No idling on either side, change triggers at the smallest threshold.
    configure(1'b1, 0, 0, 1);
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    send_random(80);
    src_idle_pct = 34;
    sink_idle_pct <= 34;

    configure(1'b1, 1, 65535, 1023);
    send_random(60);

    // Disabled again with nonzero settings.
    configure(1'b0, 7, 7, 7);
    send_random(40);

    configure(1'b1, 65535, 0, 0);
    send_random(60);

    // Largest periods: neither timer comes near expiry, so nothing triggers.
    configure(1'b1, 65535, 65535, 1023);
    send_item(mk(KIND_RESET, 0, 0, 0, 0, 0));
    src_idle_pct = 0;
    repeat (30) send_item(mk(KIND_TICK, 0, 0, 0, 0, 0));
    send_item(mk(KIND_SLOT, 40, 0, -1024, 2047, 1));
    send_item(mk(KIND_SLOT, 40, 0, -1024, 2047, 1));
    src_idle_pct = 34;

    repeat (3) begin
      configure(1'b1, $urandom_range(1, 20), $urandom_range(0, 10), $urandom_range(0, 300));
      send_random(50);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d items and checked %0d results: %0d forced, %0d periodic,",
             items_sent, sb.results_seen, sb.reports_by_reason[REASON_NONE],
             sb.reports_by_reason[REASON_PERIODIC]);
    $display("%0d pathloss and %0d power reports over disabled, minimum and maximum settings.",
             sb.reports_by_reason[REASON_PATHLOSS], sb.reports_by_reason[REASON_POWER]);
    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("power_headroom_report_trigger_core verification clean");
    end else begin
      $display("power_headroom_report_trigger_core verification failed");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/phr_pkg.sv
rtl/core/phr_in_reg.sv
rtl/core/phr_eval.sv
rtl/core/power_headroom_report_trigger_core.sv
tb/power_headroom_report_trigger_core_test.sv
